>>> src/csspan_pkg.sv
// Shared widths, register indexes and item types for the circle scanline span block.
// Used by the top level and by the square root pipeline; depends on nothing.
package csspan_pkg;

    localparam int ROW_W   = 12;
    localparam int DIM_W   = 13;
    localparam int OFS_W   = 14;
    localparam int RAD_W   = 26;
    localparam int ROOT_W  = 13;
    localparam int REM_W   = 15;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 14;
    localparam int DEF_MAX_DIM = 4096;

    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_DX    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_DY    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_RADIUS       = 3'd4;

    typedef struct packed {
        logic             covered;
        logic [RAD_W-1:0] rad;
    } t_sq_item;

    typedef struct packed {
        logic              covered;
        logic [ROOT_W-1:0] root;
    } t_sq_res;

endpackage

>>> src/csspan_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with per-stage stall control.
// Depends on csspan_pkg for widths and the item types.
module csspan_sqrt_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  csspan_pkg::t_sq_item i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output csspan_pkg::t_sq_res  o_res
);
    import csspan_pkg::*;

    localparam int N = ROOT_W;

    logic              r_vld [N];
    logic              r_cov [N];
    logic [ROOT_W-1:0] r_q   [N];
    logic [REM_W-1:0]  r_rem [N];
    logic [RAD_W-1:0]  r_v   [N];
    logic              w_en  [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic              in_vld;
            logic              in_cov;
            logic [ROOT_W-1:0] in_q;
            logic [REM_W-1:0]  in_rem;
            logic [RAD_W-1:0]  in_v;
            logic [REM_W+1:0]  rem_t;
            logic [REM_W+1:0]  trial;
            logic [ROOT_W-1:0] n_q;
            logic [REM_W-1:0]  n_rem;

            if (k == 0) begin : g_first
                assign in_vld = i_valid;
                assign in_cov = i_item.covered;
                assign in_q   = '0;
                assign in_rem = '0;
                assign in_v   = i_item.rad;
            end else begin : g_next
                assign in_vld = r_vld[k-1];
                assign in_cov = r_cov[k-1];
                assign in_q   = r_q[k-1];
                assign in_rem = r_rem[k-1];
                assign in_v   = r_v[k-1];
            end

            if (k == N - 1) begin : g_last_en
                assign w_en[k] = !r_vld[k] || i_ready;
            end else begin : g_mid_en
                assign w_en[k] = !r_vld[k] || w_en[k+1];
            end

            always_comb begin
                rem_t = {in_rem, in_v[RAD_W-1:RAD_W-2]};
                trial = {2'b00, in_q, 2'b01};
                if (rem_t >= trial) begin
                    n_rem = REM_W'(rem_t - trial);
                    n_q   = {in_q[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_t[REM_W-1:0];
                    n_q   = {in_q[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= in_vld;
                end
                if (w_en[k]) begin
                    r_cov[k] <= in_cov;
                    r_q[k]   <= n_q;
                    r_rem[k] <= n_rem;
                    r_v[k]   <= {in_v[RAD_W-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_ready       = w_en[0];
    assign o_valid       = r_vld[N-1];
    assign o_res.covered = r_cov[N-1];
    assign o_res.root    = r_q[N-1];

endmodule

>>> src/circle_scanline_span.sv
// Filled circle scanline span generator: row number in, coverage flag and clipped span out.
// Requests pass through four front stages, the 13-stage square root pipeline in
// csspan_sqrt_pipe, and two clipping stages. Throughput is one request per cycle while the
// output is not stalled; every stage holds its own valid bit and fills bubbles.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
// Depends on csspan_pkg and csspan_sqrt_pipe.
module circle_scanline_span #(
    parameter int MAX_DIM = csspan_pkg::DEF_MAX_DIM
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [csspan_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [csspan_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [15:0]                   i_s_tdata,  // [11:0] row
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,  // [12:0] span_start, [25:13] span_end
    output logic                          o_m_tuser   // [0] covered
);
    import csspan_pkg::*;

    localparam logic [DIM_W-1:0] LP_DIM_MAX =
        (MAX_DIM >= (1 << DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_DIM);

    logic [DIM_W-1:0] r_width, r_height, r_radius;
    logic [OFS_W-1:0] r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(640);
            r_height <= DIM_W'(480);
            r_dx     <= '0;
            r_dy     <= '0;
            r_radius <= DIM_W'(50);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_CENTER_DX:    r_dx     <= i_cfg_data[OFS_W-1:0];
                CFG_CENTER_DY:    r_dy     <= i_cfg_data[OFS_W-1:0];
                CFG_RADIUS:       r_radius <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0]  w_wsat, w_hsat;
    logic signed [14:0] w_cx, w_cy, w_rs;

    assign w_wsat = (r_width  > LP_DIM_MAX) ? LP_DIM_MAX : r_width;
    assign w_hsat = (r_height > LP_DIM_MAX) ? LP_DIM_MAX : r_height;
    assign w_cx   = $signed({r_dx[OFS_W-1], r_dx}) + $signed({3'b000, w_wsat[DIM_W-1:1]});
    assign w_cy   = $signed({r_dy[OFS_W-1], r_dy}) + $signed({3'b000, w_hsat[DIM_W-1:1]});
    assign w_rs   = $signed({2'b00, r_radius});

    // Stall control: a stage loads when it is empty or its successor moves.
    logic w_en1, w_en2, w_en3, w_en4, w_en5, w_en6, w_sq_ready, w_sq_valid;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    assign w_en6 = !r_v6 || i_m_tready;
    assign w_en5 = !r_v5 || w_en6;
    assign w_en4 = !r_v4 || w_sq_ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
            if (w_en5) r_v5 <= w_sq_valid;
            if (w_en6) r_v6 <= r_v5;
        end
    end

    logic [ROW_W-1:0]    r_y1;
    logic                r_cov2, r_cov3, r_cov4, r_cov5;
    logic [DIM_W-1:0]    r_ad2;
    logic [RAD_W-1:0]    r_rr3, r_dd3, r_rad4;
    logic signed [15:0]  r_from5, r_to5;
    logic                r_cov6;
    logic [DIM_W-1:0]    r_start6, r_end6;

    logic signed [14:0]  n_d, n_ad;
    logic                n_cov;
    t_sq_item            w_sq_item;
    t_sq_res             w_sq_res;
    logic signed [15:0]  w_cx16, w_half16, w_w16;
    logic [DIM_W-1:0]    n_start, n_end;

    always_comb begin
        n_d   = w_cy - $signed({3'b000, r_y1});
        n_cov = (n_d <= w_rs) && (n_d > -w_rs) && ({1'b0, r_y1} < w_hsat);
        n_ad  = (n_d < 0) ? -n_d : n_d;
    end

    assign w_cx16   = {w_cx[14], w_cx};
    assign w_half16 = $signed({3'b000, w_sq_res.root});
    assign w_w16    = $signed({3'b000, w_wsat});

    always_comb begin
        if (r_from5 < 0) begin
            n_start = '0;
        end else if (r_from5 > w_w16) begin
            n_start = w_wsat;
        end else begin
            n_start = r_from5[DIM_W-1:0];
        end
        if (r_to5 < 0) begin
            n_end = '0;
        end else if (r_to5 > w_w16) begin
            n_end = w_wsat;
        end else begin
            n_end = r_to5[DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) r_y1 <= i_s_tdata[ROW_W-1:0];
        if (w_en2) begin
            r_cov2 <= n_cov;
            r_ad2  <= n_cov ? n_ad[DIM_W-1:0] : '0;
        end
        if (w_en3) begin
            r_cov3 <= r_cov2;
            r_rr3  <= RAD_W'(r_radius) * RAD_W'(r_radius);
            r_dd3  <= RAD_W'(r_ad2) * RAD_W'(r_ad2);
        end
        if (w_en4) begin
            r_cov4 <= r_cov3;
            r_rad4 <= r_rr3 - r_dd3;
        end
        if (w_en5) begin
            r_cov5  <= w_sq_res.covered;
            r_from5 <= w_cx16 - w_half16;
            r_to5   <= w_cx16 + w_half16 + 16'sd1;
        end
        if (w_en6) begin
            r_cov6   <= r_cov5;
            r_start6 <= r_cov5 ? n_start : '0;
            r_end6   <= r_cov5 ? n_end : '0;
        end
    end

    assign w_sq_item.covered = r_cov4;
    assign w_sq_item.rad     = r_rad4;

    csspan_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .o_ready (w_sq_ready),
        .i_item  (w_sq_item),
        .o_valid (w_sq_valid),
        .i_ready (w_en5),
        .o_res   (w_sq_res)
    );

    assign o_m_tvalid = r_v6;
    assign o_m_tuser  = r_cov6;
    assign o_m_tdata  = {6'b000000, r_end6, r_start6};

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 32'd0)
        else $error("uncovered row carries a nonzero span");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[12:0] <= o_m_tdata[25:13])
        else $error("span start lies past span end");

    a_span_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[25:13] <= w_wsat)
        else $error("span end lies past the image width");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("input stalled while the output side is free");

endmodule
